// File: sv/elf_pkg.sv
// Shared types, constants and saturation helper for the Lax-Friedrichs flux block.
package elf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DIV_BITS = 2;
    localparam int DIV_STAGES = 32 / DIV_BITS;

    localparam int ADDR_W = 3;
    localparam logic [17:0] GAMMA_RESET = 18'((7 << FRAC_BITS) / 5);
    localparam logic [30:0] STAB_RESET = 31'(1 << FRAC_BITS);

    localparam logic REG_GAMMA = 1'b0;
    localparam logic REG_STAB = 1'b1;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_SAT = 2'd1;
    localparam logic [1:0] ST_BAD = 2'd2;

    localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

    typedef struct packed {
        logic sat;
        logic signed [31:0] val;
    } sat_t;

    typedef struct packed {
        logic signed [31:0] mx;
        logic signed [31:0] my;
        logic signed [31:0] r;
        logic signed [31:0] e;
    } w_t;

    typedef struct packed {
        logic signed [31:0] f00;
        logic signed [31:0] f01;
        logic signed [31:0] f11;
    } fl_t;

    typedef struct packed {
        logic bad;
        logic sat;
        w_t wi;
        w_t wo;
        logic signed [17:0] nx;
        logic signed [17:0] ny;
        fl_t fi;
        fl_t fo;
    } item_t;

    function automatic sat_t sat32(input logic signed [65:0] v);
        sat_t res;
        if (v > SAT_MAX) begin
            res.sat = 1'b1;
            res.val = 32'sh7fffffff;
        end else if (v < SAT_MIN) begin
            res.sat = 1'b1;
            res.val = 32'sh80000000;
        end else begin
            res.sat = 1'b0;
            res.val = v[31:0];
        end
        return res;
    endfunction

    function automatic logic signed [31:0] comp(input w_t w, input logic [1:0] idx);
        logic signed [31:0] res;
        case (idx)
            2'd0: res = w.mx;
            2'd1: res = w.my;
            2'd2: res = w.r;
            default: res = w.e;
        endcase
        return res;
    endfunction

endpackage

// File: sv/elf_div.sv
// Pipelined restoring divider: 64-bit magnitude by 32-bit divisor, saturated signed quotient.
module elf_div (
    input  logic               aclk,
    input  logic               adv,
    input  logic [63:0]        dividend,
    input  logic [31:0]        divisor,
    input  logic               neg,
    output logic signed [31:0] quo,
    output logic               sat
);

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] lo;
        logic [31:0] q;
        logic [31:0] d;
        logic        neg;
        logic        ovf;
    } dv_t;

    function automatic dv_t step(input dv_t s);
        dv_t o;
        logic [32:0] t;
        o = s;
        for (int j = 0; j < elf_pkg::DIV_BITS; j++) begin
            t = {o.rem, o.lo[31]};
            o.lo = {o.lo[30:0], 1'b0};
            if (t >= {1'b0, o.d}) begin
                o.rem = 32'(t - {1'b0, o.d});
                o.q = {o.q[30:0], 1'b1};
            end else begin
                o.rem = t[31:0];
                o.q = {o.q[30:0], 1'b0};
            end
        end
        return o;
    endfunction

    dv_t in_s;
    dv_t cur [elf_pkg::DIV_STAGES];
    dv_t dv_reg [elf_pkg::DIV_STAGES];
    dv_t last;

    always_comb begin
        in_s.rem = dividend[63:32];
        in_s.lo = dividend[31:0];
        in_s.q = '0;
        in_s.d = divisor;
        in_s.neg = neg;
        in_s.ovf = (dividend[63:32] >= divisor);
        cur[0] = step(in_s);
        for (int i = 1; i < elf_pkg::DIV_STAGES; i++) begin
            cur[i] = step(dv_reg[i-1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < elf_pkg::DIV_STAGES; i++) begin
                dv_reg[i] <= cur[i];
            end
        end
    end

    always_comb begin
        last = dv_reg[elf_pkg::DIV_STAGES-1];
        sat = last.ovf | (last.neg ? (last.q > 32'h80000000) : last.q[31]);
        if (sat) begin
            quo = last.neg ? 32'sh80000000 : 32'sh7fffffff;
        end else begin
            quo = last.neg ? $signed(32'(-last.q)) : $signed(last.q);
        end
    end

endmodule

// File: sv/euler_lax_friedrichs_flux_top.sv
// Lax-Friedrichs normal flux for 2D Euler states, fully pipelined.
// Depth: 9 register stages plus two 16-stage divider groups, input beat to result beat.
// Throughput: one face beat per cycle while the output is not stalled.
// A stalled output holds the whole pipeline in place; nothing is dropped or repeated.
// Reset (aresetn low, synchronous) clears all valid bits and loads the register defaults.
module euler_lax_friedrichs_flux_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [elf_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // inner_mom_x, inner_mom_y, inner_density, inner_energy,
    // outer_mom_x, outer_mom_y, outer_density, outer_energy, normal_x, normal_y, pad
    input  logic [295:0]                  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // flux_mom_x, flux_mom_y, flux_density, flux_energy
    output logic [127:0]                  m_tdata,
    // status
    output logic [1:0]                    m_tuser
);

    localparam int S = elf_pkg::DIV_STAGES;
    localparam int F = elf_pkg::FRAC_BITS;

    logic [17:0] gamma_reg;
    logic [30:0] stab_reg;
    logic adv;

    assign pready = 1'b1;
    assign adv = !m_tvalid || m_tready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gamma_reg <= elf_pkg::GAMMA_RESET;
            stab_reg <= elf_pkg::STAB_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                elf_pkg::REG_GAMMA: gamma_reg <= pwdata[17:0];
                elf_pkg::REG_STAB: stab_reg <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            elf_pkg::REG_GAMMA: prdata = {14'd0, gamma_reg};
            elf_pkg::REG_STAB: prdata = {1'b0, stab_reg};
            default: prdata = '0;
        endcase
    end

    // stage A: capture
    elf_pkg::item_t a_next, a_reg;
    logic a_v_reg;

    always_comb begin
        a_next = '0;
        a_next.wi.mx = s_tdata[31:0];
        a_next.wi.my = s_tdata[63:32];
        a_next.wi.r = s_tdata[95:64];
        a_next.wi.e = s_tdata[127:96];
        a_next.wo.mx = s_tdata[159:128];
        a_next.wo.my = s_tdata[191:160];
        a_next.wo.r = s_tdata[223:192];
        a_next.wo.e = s_tdata[255:224];
        a_next.nx = s_tdata[273:256];
        a_next.ny = s_tdata[291:274];
        a_next.bad = ($signed(s_tdata[95:64]) <= 0) || ($signed(s_tdata[223:192]) <= 0);
    end

    // stage B: squares and cross product
    elf_pkg::item_t b_reg;
    logic b_v_reg;
    logic signed [63:0] xx_reg [2];
    logic signed [63:0] yy_reg [2];
    logic signed [63:0] xy_reg [2];
    elf_pkg::w_t a_w [2];

    assign a_w[0] = a_reg.wi;
    assign a_w[1] = a_reg.wo;

    // divider group one
    elf_pkg::item_t dl1_reg [S];
    logic dl1_v_reg [S];
    elf_pkg::w_t b_w [2];
    logic signed [31:0] ke [2];
    logic signed [31:0] qxx [2];
    logic signed [31:0] qyy [2];
    logic signed [31:0] qxy [2];
    logic ke_sat [2];
    logic qxx_sat [2];
    logic qyy_sat [2];
    logic qxy_sat [2];

    assign b_w[0] = b_reg.wi;
    assign b_w[1] = b_reg.wo;

    // stages E to H and divider group two
    elf_pkg::item_t c_item, e_next, e_reg, f_next, f_reg, g_next, g_reg, h_reg;
    logic e_v_reg, f_v_reg, g_v_reg, h_v_reg;
    logic signed [18:0] gm1;
    logic signed [32:0] ediff [2];
    logic signed [51:0] t_next [2];
    logic signed [51:0] t_reg [2];
    logic signed [31:0] exx_reg [2];
    logic signed [31:0] eyy_reg [2];
    logic signed [31:0] exy_reg [2];
    logic signed [31:0] fxx_reg [2];
    logic signed [31:0] fyy_reg [2];
    logic signed [31:0] fxy_reg [2];
    elf_pkg::sat_t p_sat [2];
    logic signed [31:0] p_reg [2];
    elf_pkg::sat_t h_sat [2];
    elf_pkg::sat_t d00_sat [2];
    elf_pkg::sat_t d11_sat [2];
    logic signed [31:0] hh_reg [2];
    logic signed [63:0] mhx_reg [2];
    logic signed [63:0] mhy_reg [2];
    elf_pkg::w_t e_w [2];
    elf_pkg::w_t f_w [2];
    elf_pkg::w_t g_w [2];
    elf_pkg::w_t h_w [2];

    assign e_w[0] = e_reg.wi;
    assign e_w[1] = e_reg.wo;
    assign f_w[0] = f_reg.wi;
    assign f_w[1] = f_reg.wo;
    assign g_w[0] = g_reg.wi;
    assign g_w[1] = g_reg.wo;
    assign h_w[0] = h_reg.wi;
    assign h_w[1] = h_reg.wo;

    elf_pkg::item_t dl2_reg [S];
    logic dl2_v_reg [S];
    logic signed [31:0] f30 [2];
    logic signed [31:0] f31 [2];
    logic f30_sat [2];
    logic f31_sat [2];

    genvar gs;
    generate
        for (gs = 0; gs < 2; gs++) begin : g_state
            elf_div u_ke (
                .aclk(aclk), .adv(adv),
                .dividend($unsigned(xx_reg[gs]) + $unsigned(yy_reg[gs])),
                .divisor({b_w[gs].r[30:0], 1'b0}),
                .neg(1'b0), .quo(ke[gs]), .sat(ke_sat[gs])
            );
            elf_div u_xx (
                .aclk(aclk), .adv(adv), .dividend($unsigned(xx_reg[gs])),
                .divisor(b_w[gs].r), .neg(1'b0), .quo(qxx[gs]), .sat(qxx_sat[gs])
            );
            elf_div u_yy (
                .aclk(aclk), .adv(adv), .dividend($unsigned(yy_reg[gs])),
                .divisor(b_w[gs].r), .neg(1'b0), .quo(qyy[gs]), .sat(qyy_sat[gs])
            );
            elf_div u_xy (
                .aclk(aclk), .adv(adv),
                .dividend(xy_reg[gs][63] ? 64'(-xy_reg[gs]) : $unsigned(xy_reg[gs])),
                .divisor(b_w[gs].r), .neg(xy_reg[gs][63]), .quo(qxy[gs]),
                .sat(qxy_sat[gs])
            );
            elf_div u_hx (
                .aclk(aclk), .adv(adv),
                .dividend(mhx_reg[gs][63] ? 64'(-mhx_reg[gs]) : $unsigned(mhx_reg[gs])),
                .divisor(h_w[gs].r), .neg(mhx_reg[gs][63]), .quo(f30[gs]),
                .sat(f30_sat[gs])
            );
            elf_div u_hy (
                .aclk(aclk), .adv(adv),
                .dividend(mhy_reg[gs][63] ? 64'(-mhy_reg[gs]) : $unsigned(mhy_reg[gs])),
                .divisor(h_w[gs].r), .neg(mhy_reg[gs][63]), .quo(f31[gs]),
                .sat(f31_sat[gs])
            );
        end
    endgenerate

    assign c_item = dl1_reg[S-1];
    assign gm1 = $signed({1'b0, gamma_reg}) - (19'sd1 <<< F);

    always_comb begin
        e_next = c_item;
        f_next = e_reg;
        g_next = f_reg;
        for (int s = 0; s < 2; s++) begin
            ediff[s] = 33'(s == 0 ? c_item.wi.e : c_item.wo.e) - 33'(ke[s]);
            t_next[s] = 52'(gm1) * 52'(ediff[s]);
            e_next.sat = e_next.sat | ke_sat[s] | qxx_sat[s] | qyy_sat[s] | qxy_sat[s];
            p_sat[s] = elf_pkg::sat32(66'(t_reg[s] >>> F));
            f_next.sat = f_next.sat | p_sat[s].sat;
            h_sat[s] = elf_pkg::sat32(66'(f_w[s].e) + 66'(p_reg[s]));
            d00_sat[s] = elf_pkg::sat32(66'(fxx_reg[s]) + 66'(p_reg[s]));
            d11_sat[s] = elf_pkg::sat32(66'(fyy_reg[s]) + 66'(p_reg[s]));
            g_next.sat = g_next.sat | h_sat[s].sat | d00_sat[s].sat | d11_sat[s].sat;
        end
        g_next.fi.f00 = d00_sat[0].val;
        g_next.fi.f01 = fxy_reg[0];
        g_next.fi.f11 = d11_sat[0].val;
        g_next.fo.f00 = d00_sat[1].val;
        g_next.fo.f01 = fxy_reg[1];
        g_next.fo.f11 = d11_sat[1].val;
    end

    // stages J and K: normal projection and jump term
    elf_pkg::item_t j_item, j_next, j_reg, k_reg;
    logic j_v_reg, k_v_reg;
    logic signed [32:0] sx [4];
    logic signed [32:0] sy [4];
    logic signed [32:0] dw [4];
    logic signed [50:0] px_reg [4];
    logic signed [50:0] py_reg [4];
    logic signed [64:0] bb_reg [4];
    logic signed [65:0] tot [4];
    logic signed [65:0] tot_reg [4];
    elf_pkg::sat_t fin [4];
    logic fin_sat;
    logic m_v_reg;
    logic [127:0] m_data_reg;
    logic [1:0] m_user_reg;

    assign j_item = dl2_reg[S-1];

    always_comb begin
        j_next = j_item;
        j_next.sat = j_item.sat | f30_sat[0] | f30_sat[1] | f31_sat[0] | f31_sat[1];
        sx[0] = 33'(j_item.fi.f00) + 33'(j_item.fo.f00);
        sy[0] = 33'(j_item.fi.f01) + 33'(j_item.fo.f01);
        sx[1] = 33'(j_item.fi.f01) + 33'(j_item.fo.f01);
        sy[1] = 33'(j_item.fi.f11) + 33'(j_item.fo.f11);
        sx[2] = 33'(j_item.wi.mx) + 33'(j_item.wo.mx);
        sy[2] = 33'(j_item.wi.my) + 33'(j_item.wo.my);
        sx[3] = 33'(f30[0]) + 33'(f30[1]);
        sy[3] = 33'(f31[0]) + 33'(f31[1]);
        for (int c = 0; c < 4; c++) begin
            dw[c] = 33'(elf_pkg::comp(j_item.wi, 2'(c))) - 33'(elf_pkg::comp(j_item.wo, 2'(c)));
        end
        fin_sat = 1'b0;
        for (int c = 0; c < 4; c++) begin
            tot[c] = 66'(px_reg[c]) + 66'(py_reg[c]) + 66'(bb_reg[c]);
            fin[c] = elf_pkg::sat32(tot_reg[c] >>> (F + 1));
            fin_sat = fin_sat | fin[c].sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
            f_v_reg <= 1'b0;
            g_v_reg <= 1'b0;
            h_v_reg <= 1'b0;
            j_v_reg <= 1'b0;
            k_v_reg <= 1'b0;
            m_v_reg <= 1'b0;
            for (int i = 0; i < S; i++) begin
                dl1_v_reg[i] <= 1'b0;
                dl2_v_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            a_v_reg <= s_tvalid;
            b_v_reg <= a_v_reg;
            dl1_v_reg[0] <= b_v_reg;
            dl2_v_reg[0] <= h_v_reg;
            for (int i = 1; i < S; i++) begin
                dl1_v_reg[i] <= dl1_v_reg[i-1];
                dl2_v_reg[i] <= dl2_v_reg[i-1];
            end
            e_v_reg <= dl1_v_reg[S-1];
            f_v_reg <= e_v_reg;
            g_v_reg <= f_v_reg;
            h_v_reg <= g_v_reg;
            j_v_reg <= dl2_v_reg[S-1];
            k_v_reg <= j_v_reg;
            m_v_reg <= k_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_reg <= a_next;
            b_reg <= a_reg;
            dl1_reg[0] <= b_reg;
            dl2_reg[0] <= h_reg;
            for (int i = 1; i < S; i++) begin
                dl1_reg[i] <= dl1_reg[i-1];
                dl2_reg[i] <= dl2_reg[i-1];
            end
            e_reg <= e_next;
            f_reg <= f_next;
            g_reg <= g_next;
            h_reg <= g_reg;
            j_reg <= j_next;
            k_reg <= j_reg;
            for (int s = 0; s < 2; s++) begin
                xx_reg[s] <= 64'(a_w[s].mx) * 64'(a_w[s].mx);
                yy_reg[s] <= 64'(a_w[s].my) * 64'(a_w[s].my);
                xy_reg[s] <= 64'(a_w[s].mx) * 64'(a_w[s].my);
                t_reg[s] <= t_next[s];
                exx_reg[s] <= qxx[s];
                eyy_reg[s] <= qyy[s];
                exy_reg[s] <= qxy[s];
                fxx_reg[s] <= exx_reg[s];
                fyy_reg[s] <= eyy_reg[s];
                fxy_reg[s] <= exy_reg[s];
                p_reg[s] <= p_sat[s].val;
                hh_reg[s] <= h_sat[s].val;
                mhx_reg[s] <= 64'(g_w[s].mx) * 64'(hh_reg[s]);
                mhy_reg[s] <= 64'(g_w[s].my) * 64'(hh_reg[s]);
            end
            for (int c = 0; c < 4; c++) begin
                px_reg[c] <= 51'(sx[c]) * 51'(j_item.nx);
                py_reg[c] <= 51'(sy[c]) * 51'(j_item.ny);
                bb_reg[c] <= 65'($signed({1'b0, stab_reg})) * 65'(dw[c]);
                tot_reg[c] <= tot[c];
            end
            if (k_reg.bad) begin
                m_data_reg <= '0;
                m_user_reg <= elf_pkg::ST_BAD;
            end else begin
                m_data_reg <= {fin[3].val, fin[2].val, fin[1].val, fin[0].val};
                m_user_reg <= (k_reg.sat || fin_sat) ? elf_pkg::ST_SAT : elf_pkg::ST_OK;
            end
        end
    end

    assign m_tvalid = m_v_reg;
    assign m_tdata = m_data_reg;
    assign m_tuser = m_user_reg;

endmodule

// File: sv/elf_check.sv
// Port-level checker for the flux block, bound to the top level.
module elf_check (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [127:0]               m_tdata,
    input logic [1:0]                 m_tuser
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output backpressure");

    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == elf_pkg::ST_BAD |-> m_tdata == '0)
        else $error("nonpositive density beat carries nonzero flux");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser == elf_pkg::ST_OK || m_tuser == elf_pkg::ST_SAT
                     || m_tuser == elf_pkg::ST_BAD)
        else $error("undefined status code");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind euler_lax_friedrichs_flux_top elf_check u_elf_check (.*);

// File: sim/euler_lax_friedrichs_flux_checker.sv
// Checker for the Lax-Friedrichs flux block: tracks registers, predicts each face, compares results.
`timescale 1ns / 100ps
module euler_lax_friedrichs_flux_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [295:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [127:0] m_tdata,
    input  logic [1:0]   m_tuser,
    output int           errors,
    output int           flux_pending
);

    typedef struct {
        logic [31:0] flux[4];
        logic [1:0]  status;
    } face_flux_t;

    longint gamma_q;
    longint stab_q;
    bit clipped;
    face_flux_t flux_queue[$];

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) begin
            clipped = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            clipped = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic void state_flux(input longint w[4], output longint f[8]);
        longint mx, my, r, e, ke, gm1, p, h;
        longint unsigned sq, keu;
        mx = w[0];
        my = w[1];
        r = w[2];
        e = w[3];
        sq = $unsigned(mx * mx) + $unsigned(my * my);
        keu = sq / ($unsigned(r) * 64'd2);
        if (keu > 64'd2147483647) begin
            clipped = 1'b1;
            ke = 64'sd2147483647;
        end else begin
            ke = longint'(keu);
        end
        gm1 = gamma_q - (64'sd1 <<< elf_pkg::FRAC_BITS);
        p = clip32((gm1 * (e - ke)) >>> elf_pkg::FRAC_BITS);
        h = clip32(e + p);
        f[0] = clip32(clip32(mx * mx / r) + p);
        f[1] = clip32(mx * my / r);
        f[2] = clip32(my * mx / r);
        f[3] = clip32(clip32(my * my / r) + p);
        f[4] = mx;
        f[5] = my;
        f[6] = clip32(mx * h / r);
        f[7] = clip32(my * h / r);
    endfunction

    function automatic face_flux_t predict_face(input logic [295:0] d);
        face_flux_t res;
        longint wi[4], wo[4], fi[8], fo[8], n[2];
        longint a, b, bh, bl;
        for (int c = 0; c < 4; c++) begin
            wi[c] = longint'($signed(d[32*c +: 32]));
            wo[c] = longint'($signed(d[128 + 32*c +: 32]));
        end
        n[0] = longint'($signed(d[256 +: 18]));
        n[1] = longint'($signed(d[274 +: 18]));
        if (wi[2] <= 0 || wo[2] <= 0) begin
            for (int c = 0; c < 4; c++) res.flux[c] = '0;
            res.status = elf_pkg::ST_BAD;
            return res;
        end
        clipped = 1'b0;
        state_flux(wi, fi);
        state_flux(wo, fo);
        for (int c = 0; c < 4; c++) begin
            a = 0;
            for (int k = 0; k < 2; k++) a += (fi[2*c+k] + fo[2*c+k]) * n[k];
            b = stab_q * (wi[c] - wo[c]);
            bh = b >>> (elf_pkg::FRAC_BITS + 1);
            bl = b - (bh <<< (elf_pkg::FRAC_BITS + 1));
            res.flux[c] = 32'(clip32(bh + ((a + bl) >>> (elf_pkg::FRAC_BITS + 1))));
        end
        res.status = clipped ? elf_pkg::ST_SAT : elf_pkg::ST_OK;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        errors++;
    endtask

    assign flux_pending = flux_queue.size();

    initial errors = 0;

    always @(posedge aclk) begin
        face_flux_t want;
        if (!aresetn) begin
            gamma_q <= longint'(elf_pkg::GAMMA_RESET);
            stab_q <= longint'(elf_pkg::STAB_RESET);
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == elf_pkg::REG_GAMMA) gamma_q <= longint'(pwdata[17:0]);
                else stab_q <= longint'(pwdata[30:0]);
            end
            if (s_tvalid && s_tready)
                flux_queue.insert(flux_queue.size(), predict_face(s_tdata));
            if (m_tvalid && m_tready) begin
                if (flux_queue.size() == 0) begin
                    report_mismatch("unexpected beat", m_tdata[31:0], '0);
                end else begin
                    want = flux_queue.pop_front();
                    if (m_tdata[31:0] !== want.flux[0])
                        report_mismatch("flux_mom_x", m_tdata[31:0], want.flux[0]);
                    if (m_tdata[63:32] !== want.flux[1])
                        report_mismatch("flux_mom_y", m_tdata[63:32], want.flux[1]);
                    if (m_tdata[95:64] !== want.flux[2])
                        report_mismatch("flux_density", m_tdata[95:64], want.flux[2]);
                    if (m_tdata[127:96] !== want.flux[3])
                        report_mismatch("flux_energy", m_tdata[127:96], want.flux[3]);
                    if (m_tuser !== want.status)
                        report_mismatch("status", 32'(m_tuser), 32'(want.status));
                end
            end
        end
    end
endmodule

// File: sim/tb_euler_lax_friedrichs_flux_top.sv
// Testbench top for the Lax-Friedrichs flux block: clock, reset, register writes, face stimulus.
`timescale 1ns / 100ps
module tb_euler_lax_friedrichs_flux_top;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 60;
    localparam logic [2:0] GAMMA_ADDR = {elf_pkg::REG_GAMMA, 2'b00};
    localparam logic [2:0] STAB_ADDR = {elf_pkg::REG_STAB, 2'b00};

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [295:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic [1:0]   m_tuser;
    int           errors;
    int           flux_pending;
    int           cycles = 0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    euler_lax_friedrichs_flux_top DUT (.*);

    euler_lax_friedrichs_flux_checker u_checker (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("euler_lax_friedrichs_flux_top verification failed");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    int ready_hold = 0;
    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) ready_hold <= gap_len();
        end
    end

    function automatic logic [295:0] pack_face(input logic [31:0] w[8],
                                               input logic [17:0] nx, input logic [17:0] ny);
        logic [295:0] d;
        d = '0;
        for (int i = 0; i < 8; i++) d[32*i +: 32] = w[i];
        d[256 +: 18] = nx;
        d[274 +: 18] = ny;
        return d;
    endfunction

    function automatic logic [17:0] rand_normal();
        return 18'($signed($urandom_range(0, 131072)) - 65536);
    endfunction

    function automatic logic [295:0] rand_face();
        logic [31:0] w[8];
        int kind;
        kind = $urandom_range(0, 99);
        for (int s = 0; s < 2; s++) begin
            if (kind < 75) begin
                w[4*s]   = 32'($signed($urandom_range(0, 16 << 16)) - (8 << 16));
                w[4*s+1] = 32'($signed($urandom_range(0, 16 << 16)) - (8 << 16));
                w[4*s+2] = 32'($urandom_range(1 << 10, 20 << 16));
                w[4*s+3] = 32'($signed($urandom_range(0, 60 << 16)) - (10 << 16));
            end else begin
                for (int c = 0; c < 4; c++) w[4*s+c] = $urandom;
                if (kind < 92) w[4*s+2] = {1'b0, w[4*s+2][30:0]} | 32'd1;
            end
        end
        return pack_face(w, rand_normal(), rand_normal());
    endfunction

    task automatic send_face(input logic [295:0] d);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid = 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_tdata = d;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic quiesce();
        s_tvalid = 1'b0;
        while (flux_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] val);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = val;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic directed_faces();
        logic [31:0] w[8];
        logic [31:0] edge_val[4];
        edge_val = '{32'h7fffffff, 32'h80000000, 32'h00000000, 32'h00010000};
        // typical gas in motion on both sides
        w = '{32'h00010000, 32'h00008000, 32'h00010000, 32'h00030000,
              32'hffff0000, 32'h00004000, 32'h00020000, 32'h00050000};
        send_face(pack_face(w, 18'h10000, 18'h00000));
        send_face(pack_face(w, 18'h30000, 18'h00000));
        send_face(pack_face(w, 18'h00000, 18'h30000));
        send_face(pack_face(w, 18'h0b505, 18'h34afb));
        // zero and negative density on either side
        w[2] = 32'h0;
        send_face(pack_face(w, 18'h10000, 18'h10000));
        w[2] = 32'h00010000;
        w[6] = 32'h80000000;
        send_face(pack_face(w, 18'h10000, 18'h10000));
        w[6] = 32'hffffffff;
        send_face(pack_face(w, 18'h10000, 18'h10000));
        // extreme fields, smallest densities drive saturation
        for (int i = 0; i < 4; i++) begin
            w = '{edge_val[i], edge_val[3-i], 32'h00000001, edge_val[i],
                  edge_val[3-i], edge_val[i], 32'h7fffffff, edge_val[3-i]};
            send_face(pack_face(w, 18'h10000, 18'h30000));
            w[2] = 32'h7fffffff;
            w[6] = 32'h00000001;
            send_face(pack_face(w, 18'h30000, 18'h10000));
        end
        w = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
              32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000};
        send_face(pack_face(w, 18'h10000, 18'h10000));
        send_face(pack_face(w, 18'h00000, 18'h00000));
    endtask

    initial begin
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        directed_faces();
        for (int i = 0; i < 80; i++) send_face(rand_face());
        quiesce();

        apb_write(GAMMA_ADDR, 32'd65536);
        apb_write(STAB_ADDR, 32'd0);
        directed_faces();
        for (int i = 0; i < 70; i++) send_face(rand_face());
        quiesce();

        apb_write(GAMMA_ADDR, 32'd196608);
        apb_write(STAB_ADDR, 32'h7fffffff);
        directed_faces();
        for (int i = 0; i < 70; i++) send_face(rand_face());
        quiesce();

        for (int ph = 0; ph < 3; ph++) begin
            apb_write(GAMMA_ADDR, $urandom);
            apb_write(STAB_ADDR, $urandom);
            for (int i = 0; i < 45; i++) send_face(rand_face());
            quiesce();
        end

        apb_write(GAMMA_ADDR, 32'(elf_pkg::GAMMA_RESET));
        apb_write(STAB_ADDR, 32'(elf_pkg::STAB_RESET));
        for (int i = 0; i < 40; i++) send_face(rand_face());
        quiesce();

        if (errors == 0) begin
            $display("euler_lax_friedrichs_flux_top verification clean");
        end else begin
            $display("euler_lax_friedrichs_flux_top verification failed");
        end
        $finish;
    end
endmodule
